// ===== sv/twsu_pkg.sv =====
`default_nettype none

package twsu_pkg;

  localparam int WHEEL_SLOTS_DEF = 1024;
  localparam int MAX_TIMERS_DEF  = 64;

  localparam int DELAY_W  = 16;
  localparam int HANDLE_W = 6;
  localparam int KIND_W   = 3;
  localparam int TICK_W   = 32;
  localparam int LINK_W   = HANDLE_W + 1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TOO_FAR   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POOL_FULL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd4;

  // slot head or list link: valid flag over a handle
  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
  } link_t;

  typedef struct packed {
    logic                set;
    logic [HANDLE_W-1:0] set_h;
    logic                clr;
    logic [HANDLE_W-1:0] clr_h;
  } pool_cmd_t;

  typedef struct packed {
    logic                full;
    logic [HANDLE_W-1:0] free_h;
  } pool_stat_t;

endpackage

`default_nettype wire

// ===== sv/twsu_ram.sv =====
`default_nettype none

module twsu_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/twsu_pool.sv =====
`default_nettype none

module twsu_pool #(
  parameter int MAX_TIMERS = 64,
  parameter int HW         = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire twsu_pkg::pool_cmd_t    cmd,
  output twsu_pkg::pool_stat_t        stat
);

  logic [MAX_TIMERS-1:0] in_use;

  // lowest free handle wins
  always_comb begin
    stat.full   = 1'b1;
    stat.free_h = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        stat.full   = 1'b0;
        stat.free_h = twsu_pkg::HANDLE_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      if (cmd.set) begin
        in_use[cmd.set_h[HW-1:0]] <= 1'b1;
      end
      if (cmd.clr) begin
        in_use[cmd.clr_h[HW-1:0]] <= 1'b0;
      end
    end
  end

  a_set_free: assert property (@(posedge clk) disable iff (rst)
    cmd.set |-> !in_use[cmd.set_h[HW-1:0]])
    else $error("allocating a handle already in use");

  a_clr_used: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |-> in_use[cmd.clr_h[HW-1:0]])
    else $error("releasing a handle not in use");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.set && cmd.clr))
    else $error("allocate and release in the same cycle");

endmodule

`default_nettype wire

// ===== sv/twsu_slot_unit.sv =====
`default_nettype none

module twsu_slot_unit #(
  parameter int WHEEL_SLOTS = 1024,
  parameter int SW          = 10
) (
  input  wire logic [twsu_pkg::TICK_W-1:0]  tick_count,
  input  wire logic [SW-1:0]                now_slot,
  input  wire logic [twsu_pkg::DELAY_W-1:0] addend,
  output logic      [twsu_pkg::TICK_W-1:0]  tick_sum,
  output logic      [SW-1:0]                slot_sum
);

  localparam logic [16:0] SLOTS = 17'(WHEEL_SLOTS);

  logic [32:0] wide;
  logic [16:0] near;
  logic [16:0] near_wrap;

  // now_slot tracks tick_count mod slots; a carry out of the 32-bit counter
  // leaves a wrapped sum below the addend, which is already the slot
  always_comb begin
    wide      = {1'b0, tick_count} + 33'(addend);
    near      = 17'(now_slot) + 17'(addend);
    near_wrap = near - SLOTS;
    tick_sum  = wide[31:0];
    if (wide[32]) begin
      slot_sum = wide[SW-1:0];
    end else if (near >= SLOTS) begin
      slot_sum = near_wrap[SW-1:0];
    end else begin
      slot_sum = near[SW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/timing_wheel_scheduler_unit.sv =====
// Add: ADD_CALC, then ADD_READ and ADD_WRITE load the result into the output
// register, ADD_CALC alone when rejected; the slot head memory port takes one
// read and one write. Tick: TICK_HEAD gives an empty result, else TICK_WALK gives
// the expiries in turn from the registered link read, held while the output stalls;
// s_tready rises as the last result loads. Reset: synchronous; afterwards a
// clearing pass empties the slot head memory, with s_tready low throughout.
`default_nettype none

module timing_wheel_scheduler_unit #(
  parameter int WHEEL_SLOTS = twsu_pkg::WHEEL_SLOTS_DEF,
  parameter int MAX_TIMERS  = twsu_pkg::MAX_TIMERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // delay_ticks[15:0]
  input  wire logic [0:0]  s_tuser,   // action[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // handle[5:0], now_ticks[37:6], zero[39:38]
  output logic      [2:0]  m_tuser,   // kind[2:0]
  output logic             m_tlast
);

  localparam int SW    = $clog2(WHEEL_SLOTS);
  localparam int HW    = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W = $clog2(MAX_TIMERS + 1);
  localparam int LW    = twsu_pkg::LINK_W;
  localparam int HDW   = twsu_pkg::HANDLE_W;

  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_ADD_CALC  = 3'd2;
  localparam logic [2:0] ST_ADD_READ  = 3'd3;
  localparam logic [2:0] ST_ADD_WRITE = 3'd4;
  localparam logic [2:0] ST_TICK_HEAD = 3'd5;
  localparam logic [2:0] ST_TICK_WALK = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [SW-1:0]                     clr_addr;
  logic [twsu_pkg::TICK_W-1:0]       tick_count;
  logic [SW-1:0]                     now_slot;
  logic                              act_tick;
  logic [twsu_pkg::DELAY_W-1:0]      delay;
  logic [SW-1:0]                     add_slot;
  logic [HDW-1:0]                    add_h;
  logic [HDW-1:0]                    cur_h;
  logic [CNT_W-1:0]                  walk_cnt;

  logic                              slot_we;
  logic                              slot_re;
  logic [SW-1:0]                     slot_addr;
  logic [LW-1:0]                     slot_wdata;
  logic [LW-1:0]                     slot_rdata;
  logic                              link_we;
  logic                              link_re;
  logic [HW-1:0]                     link_addr;
  logic [LW-1:0]                     link_rdata;

  twsu_pkg::link_t                   head;
  twsu_pkg::link_t                   nxt;
  twsu_pkg::pool_cmd_t               pool_cmd;
  twsu_pkg::pool_stat_t              pool_stat;

  logic [twsu_pkg::DELAY_W-1:0]      addend;
  logic [twsu_pkg::TICK_W-1:0]       tick_sum;
  logic [SW-1:0]                     slot_sum;

  logic                              too_far;
  logic                              head_ok;
  logic                              walk_more;
  logic                              out_free;
  logic                              out_load;
  logic [twsu_pkg::KIND_W-1:0]       out_kind;
  logic [HDW-1:0]                    out_handle;
  logic                              out_last;
  logic                              finish;
  logic                              add_latch;
  logic                              head_take;
  logic                              walk_adv;

  twsu_ram #(
    .DEPTH (WHEEL_SLOTS),
    .AW    (SW),
    .DW    (LW)
  ) u_slot_heads (
    .clk   (clk),
    .we    (slot_we),
    .re    (slot_re),
    .addr  (slot_addr),
    .wdata (slot_wdata),
    .rdata (slot_rdata)
  );

  twsu_ram #(
    .DEPTH (MAX_TIMERS),
    .AW    (HW),
    .DW    (LW)
  ) u_next_link (
    .clk   (clk),
    .we    (link_we),
    .re    (link_re),
    .addr  (link_addr),
    .wdata (slot_rdata),
    .rdata (link_rdata)
  );

  twsu_pool #(
    .MAX_TIMERS (MAX_TIMERS),
    .HW         (HW)
  ) u_pool (
    .clk  (clk),
    .rst  (rst),
    .cmd  (pool_cmd),
    .stat (pool_stat)
  );

  // shared adder: expiry slot for an add, counter advance for a tick
  twsu_slot_unit #(
    .WHEEL_SLOTS (WHEEL_SLOTS),
    .SW          (SW)
  ) u_slot_unit (
    .tick_count (tick_count),
    .now_slot   (now_slot),
    .addend     (addend),
    .tick_sum   (tick_sum),
    .slot_sum   (slot_sum)
  );

  assign addend    = act_tick ? twsu_pkg::DELAY_W'(1) : delay;
  assign head      = twsu_pkg::link_t'(slot_rdata);
  assign nxt       = twsu_pkg::link_t'(link_rdata);
  assign too_far   = {1'b0, delay} >= 17'(WHEEL_SLOTS);
  assign head_ok   = head.valid && ({1'b0, head.handle} < LW'(MAX_TIMERS));
  assign walk_more = nxt.valid && ({1'b0, nxt.handle} < LW'(MAX_TIMERS))
                     && (walk_cnt < CNT_W'(MAX_TIMERS));
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    slot_addr  = now_slot;
    slot_wdata = '0;
    link_we    = 1'b0;
    link_re    = 1'b0;
    link_addr  = add_h[HW-1:0];
    pool_cmd   = '0;
    out_load   = 1'b0;
    out_kind   = twsu_pkg::KIND_ADDED;
    out_handle = '0;
    out_last   = 1'b1;
    finish     = 1'b0;
    add_latch  = 1'b0;
    head_take  = 1'b0;
    walk_adv   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        slot_we   = 1'b1;
        slot_addr = clr_addr;
        if (clr_addr == SW'(WHEEL_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser[0]) begin
            slot_re    = 1'b1;
            state_next = ST_TICK_HEAD;
          end else begin
            state_next = ST_ADD_CALC;
          end
        end
      end
      ST_ADD_CALC: begin
        if (too_far || pool_stat.full) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_kind   = too_far ? twsu_pkg::KIND_TOO_FAR : twsu_pkg::KIND_POOL_FULL;
            state_next = ST_IDLE;
          end
        end else begin
          add_latch  = 1'b1;
          state_next = ST_ADD_READ;
        end
      end
      ST_ADD_READ: begin
        slot_re    = 1'b1;
        slot_addr  = add_slot;
        state_next = ST_ADD_WRITE;
      end
      ST_ADD_WRITE: begin
        if (out_free) begin
          // push onto the front: old head becomes the new timer's link
          slot_we        = 1'b1;
          slot_addr      = add_slot;
          slot_wdata     = {1'b1, add_h};
          link_we        = 1'b1;
          pool_cmd.set   = 1'b1;
          pool_cmd.set_h = add_h;
          out_load       = 1'b1;
          out_kind       = twsu_pkg::KIND_ADDED;
          out_handle     = add_h;
          state_next     = ST_IDLE;
        end
      end
      ST_TICK_HEAD: begin
        if (head_ok) begin
          link_re    = 1'b1;
          link_addr  = head.handle[HW-1:0];
          head_take  = 1'b1;
          state_next = ST_TICK_WALK;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_kind   = twsu_pkg::KIND_EMPTY;
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TICK_WALK: begin
        // link of the current timer is in link_rdata; fetch the one after
        if (out_free) begin
          out_load       = 1'b1;
          out_kind       = twsu_pkg::KIND_EXPIRED;
          out_handle     = cur_h;
          out_last       = !walk_more;
          pool_cmd.clr   = 1'b1;
          pool_cmd.clr_h = cur_h;
          if (walk_more) begin
            link_re   = 1'b1;
            link_addr = nxt.handle[HW-1:0];
            walk_adv  = 1'b1;
          end else begin
            finish     = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // empty the slot just walked
    if (finish) begin
      slot_we    = 1'b1;
      slot_addr  = now_slot;
      slot_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      tick_count <= '0;
      now_slot   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + SW'(1);
      end
      if (finish) begin
        tick_count <= tick_sum;
        now_slot   <= slot_sum;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act_tick <= s_tuser[0];
      delay    <= s_tdata;
    end
    if (add_latch) begin
      add_slot <= slot_sum;
      add_h    <= pool_stat.free_h;
    end
    if (head_take) begin
      cur_h    <= head.handle;
      walk_cnt <= CNT_W'(1);
    end else if (walk_adv) begin
      cur_h    <= nxt.handle;
      walk_cnt <= walk_cnt + CNT_W'(1);
    end
    if (out_load) begin
      m_tdata <= {2'b00, tick_count, out_handle};
      m_tuser <= out_kind;
      m_tlast <= out_last;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result loaded over an untaken transfer");

  a_tick_adv: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last && act_tick && state != ST_ADD_CALC)
      |=> (tick_count == $past(tick_count) + 32'd1))
    else $error("tick counter did not advance after the final tick result");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!m_tvalid && !s_tready))
    else $error("traffic during the clearing pass");

endmodule

`default_nettype wire
